// ===== rtl/edb_pkg.sv =====
// Package for the error diffusion buffer: widths, register codes, types and helpers.
// No dependencies.
package edb_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int StoreW       = 24;
  localparam int SrcW         = 12;
  localparam int ErrW         = 16;
  localparam int AdjW         = 16;
  localparam int DimW         = 9;
  localparam int WgtW         = 4;
  localparam int NumTaps      = 6;
  localparam int CfgAddrW     = 4;

  localparam logic [CfgAddrW-1:0] RegWidth  = 4'h0;
  localparam logic [CfgAddrW-1:0] RegHeight = 4'h4;
  localparam logic [CfgAddrW-1:0] RegKernel = 4'h8;
  localparam logic [CfgAddrW-1:0] RegAvg    = 4'hC;

  localparam logic FuncRead = 1'b0;
  localparam logic FuncDist = 1'b1;

  typedef logic signed [StoreW-1:0] store_t;

  typedef struct packed {
    logic capture;
    logic clear_en;
    logic rd_en;
    logic wr_en;
    logic avg;
    logic load;
  } edb_cmd_t;

  function automatic store_t sat_store(input logic signed [StoreW+1:0] v);
    logic signed [StoreW+1:0] hi;
    logic signed [StoreW+1:0] lo;
    hi = (StoreW+2)'(signed'({1'b0, {(StoreW-1){1'b1}}}));
    lo = -hi - (StoreW+2)'(1);
    if (v > hi) sat_store = store_t'(hi);
    else if (v < lo) sat_store = store_t'(lo);
    else sat_store = store_t'(v);
  endfunction

  function automatic logic signed [AdjW-1:0] adjust(input logic [SrcW-1:0] src,
                                                    input store_t e);
    logic signed [StoreW+1:0] sum;
    logic signed [StoreW+1:0] q;
    sum = signed'({10'd0, src, 4'd0}) + (StoreW+2)'(e);
    q = (sum < 0) ? -((-sum) >>> 4) : (sum >>> 4);
    if (q > 32767) adjust = 16'sh7FFF;
    else if (q < -32768) adjust = -16'sh8000;
    else adjust = AdjW'(q);
  endfunction

endpackage

// ===== rtl/edb_if.sv =====
// Valid/ready channel interface carrying one word of payload type T.
// Depends on nothing.
interface edb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/edb_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module edb_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

// ===== rtl/edb_datapath.sv =====
// Datapath: three error stores, division by three, saturating accumulation.
// Depends on edb_pkg and edb_ram.
module edb_datapath import edb_pkg::*; #(
  parameter int AddrW = 16
) (
  input  logic             clk,
  input  edb_cmd_t         cmd,
  input  logic [AddrW-1:0] addr,
  input  logic [WgtW-1:0]  wgt,
  input  logic [3*ErrW-1:0] err,
  input  logic [3*SrcW-1:0] src,
  output logic [3*AdjW-1:0] adj
);
  logic [3*StoreW-1:0] rdata;
  logic [3*StoreW-1:0] wdata;
  logic [3*AdjW-1:0]   adj_nxt;
  logic [3*AdjW-1:0]   adj_r;
  logic [3*StoreW-1:0] prod_r;
  logic [3*StoreW-1:0] prod_nxt;
  logic [3*ErrW-1:0]   err_r;
  logic [3*SrcW-1:0]   src_r;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    store_t e;
    logic signed [StoreW+1:0] ediv;
    logic signed [2*StoreW+3:0] mul;
    edb_ram #(.Width(StoreW), .Depth(2**AddrW)) u_ram (
      .clk, .we(cmd.wr_en), .re(cmd.rd_en), .addr,
      .wdata(wdata[c*StoreW +: StoreW]), .rdata(rdata[c*StoreW +: StoreW]));
    assign prod_nxt[c*StoreW +: StoreW] = store_t'(signed'(err_r[c*ErrW +: ErrW])) *
                                          store_t'(signed'({1'b0, wgt}));
    assign e = store_t'(rdata[c*StoreW +: StoreW]);
    // Truncating divide by three: multiply the magnitude by ceil(2^26/3).
    assign mul = (2*StoreW+4)'(e < 0 ? -(StoreW+2)'(e) : (StoreW+2)'(e)) * 22369622;
    assign ediv = (e < 0) ? -(StoreW+2)'(mul >>> 26) : (StoreW+2)'(mul >>> 26);
    assign adj_nxt[c*AdjW +: AdjW] = adjust(src_r[c*SrcW +: SrcW],
        cmd.avg ? store_t'(ediv) : e);
    assign wdata[c*StoreW +: StoreW] = cmd.clear_en ? '0 :
        sat_store((StoreW+2)'(e) + (StoreW+2)'(store_t'(prod_r[c*StoreW +: StoreW])));
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.capture) begin
      err_r <= err;
      src_r <= src;
    end
    if (cmd.load) adj_r <= adj_nxt;
  end
  assign adj = adj_r;
endmodule

// ===== rtl/edb_ctrl.sv =====
// Controller: clearing pass, per-item sequencing of read-modify-writes, handshakes.
// Depends on edb_pkg.
module edb_ctrl import edb_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  parameter int AddrW     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [7:0]       in_x,
  input  logic [7:0]       in_y,
  input  logic [DimW-1:0]  width,
  input  logic [DimW-1:0]  height,
  input  logic [23:0]      kernel,
  input  logic             avg_mode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_cerr,
  output logic             out_zero,
  output edb_cmd_t         cmd,
  output logic [AddrW-1:0] addr,
  output logic [WgtW-1:0]  wgt
);
  localparam int XW = $clog2(MaxWidth);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RDWAIT, S_DREAD, S_DWRITE, S_OUT} state_t;
  state_t state_r;
  logic [AddrW-1:0] clr_r;
  logic [2:0] tap_r;
  logic [8:0] x_r, y_r;
  logic func_r, cerr_r, avg_r;
  logic [12:0] ew, eh;
  logic [9:0] tx, ty;
  logic tap_ok;
  logic [WgtW-1:0] tw;

  assign ew = (width  > DimW'(MaxWidth)  && MaxWidth  < 512) ? 13'(MaxWidth)  : 13'(width);
  assign eh = (height > DimW'(MaxHeight) && MaxHeight < 512) ? 13'(MaxHeight) : 13'(height);

  always_comb begin
    tx = 10'(x_r);
    ty = 10'(y_r);
    case (tap_r)
      3'd0: begin tx = 10'(x_r) - 10'd1; ty = 10'(y_r) + 10'd1; end
      3'd1: ty = 10'(y_r) + 10'd1;
      3'd2: begin tx = 10'(x_r) + 10'd1; ty = 10'(y_r) + 10'd1; end
      3'd3: tx = 10'(x_r) + 10'd1;
      3'd4: tx = 10'(x_r) + 10'd2;
      3'd5: ty = 10'(y_r) + 10'd2;
      default: ;
    endcase
    tw = kernel[tap_r*WgtW +: WgtW];
    tap_ok = (tw != '0) && !(tap_r == 3'd0 && x_r == '0) &&
             (13'(tx) < ew) && (13'(ty) < eh);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_cerr  = cerr_r;
  assign out_zero  = func_r | cerr_r;
  assign wgt = tw;

  always_comb begin
    cmd = '0;
    cmd.avg = avg_r;
    addr = AddrW'(ty) * AddrW'(MaxWidth) + AddrW'(tx[XW-1:0]);
    case (state_r)
      S_CLEAR: begin cmd.clear_en = 1'b1; cmd.wr_en = 1'b1; addr = clr_r; end
      S_IDLE: begin
        addr = AddrW'(in_y) * AddrW'(MaxWidth) + AddrW'(in_x);
        cmd.rd_en = in_valid && in_func == FuncRead;
        cmd.capture = in_valid;
      end
      S_RDWAIT: cmd.load = 1'b1;
      S_DREAD: cmd.rd_en = tap_ok;
      S_DWRITE: cmd.wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          x_r <= 9'(in_x); y_r <= 9'(in_y); func_r <= in_func;
          avg_r <= avg_mode && in_y != '0;
          cerr_r <= !(13'(in_x) < ew && 13'(in_y) < eh);
          tap_r <= '0;
          if (!(13'(in_x) < ew && 13'(in_y) < eh)) state_r <= S_OUT;
          else if (in_func == FuncRead) state_r <= S_RDWAIT;
          else state_r <= S_DREAD;
        end
        S_RDWAIT: state_r <= S_OUT;
        S_DREAD: begin
          if (tap_ok) state_r <= S_DWRITE;
          else if (tap_r == 3'(NumTaps-1)) state_r <= S_OUT;
          else tap_r <= tap_r + 1'b1;
        end
        S_DWRITE: begin
          if (tap_r == 3'(NumTaps-1)) state_r <= S_OUT;
          else begin tap_r <= tap_r + 1'b1; state_r <= S_DREAD; end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd.wr_en |-> !cmd.rd_en)
    else $error("store read and write in one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWRITE) |-> $past(state_r == S_DREAD))
    else $error("write without preceding read");
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
    else $error("input taken while result pending");
endmodule

// ===== rtl/error_diffusion_buffer.sv =====
// Top level of the error diffusion buffer: APB register file, controller, datapath.
// Depends on edb_pkg, edb_if, edb_ctrl and edb_datapath.
//
//   channel  direction  handshake
//   in       sink       in.valid / in.ready
//   out      source     out.valid / out.ready
//   cfg      APB        psel, penable, pwrite, pready
//
// A read word passes through the read-wait state before its result is offered; a
// distribute visits a read state for each of the six neighbour taps and a write
// state for each active one, as the read-modify-write shares the one store port.
// After reset a clearing pass zeroes every store word before the first word is
// taken. One word is worked on at a time; a stalled result holds.
module error_diffusion_buffer import edb_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk,
  input  logic                rst_n,
  edb_if.sink                 in,
  edb_if.source               out,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  localparam int AddrW = $clog2(MAX_WIDTH*MAX_HEIGHT);
  logic [DimW-1:0] width_r, height_r;
  logic [23:0] kernel_r;
  logic avg_r;
  edb_cmd_t cmd;
  logic [AddrW-1:0] addr;
  logic [WgtW-1:0] wgt;
  logic [3*AdjW-1:0] adj;
  logic cerr, zero;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256; height_r <= 9'd192; kernel_r <= '0; avg_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        RegWidth:  width_r  <= cfg_pwdata[DimW-1:0];
        RegHeight: height_r <= cfg_pwdata[DimW-1:0];
        RegKernel: kernel_r <= cfg_pwdata[23:0];
        RegAvg:    avg_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      RegWidth:  cfg_prdata = 32'(width_r);
      RegHeight: cfg_prdata = 32'(height_r);
      RegKernel: cfg_prdata = 32'(kernel_r);
      RegAvg:    cfg_prdata = 32'(avg_r);
      default:   cfg_prdata = '0;
    endcase
  end

  edb_ctrl #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT), .AddrW(AddrW)) u_ctrl (
    .clk, .rst_n, .in_valid(in.valid), .in_ready(in.ready), .in_func(in.data.func),
    .in_x(in.data.pos_x), .in_y(in.data.pos_y), .width(width_r), .height(height_r),
    .kernel(kernel_r), .avg_mode(avg_r), .out_valid(out.valid), .out_ready(out.ready),
    .out_cerr(cerr), .out_zero(zero), .cmd, .addr, .wgt);

  edb_datapath #(.AddrW(AddrW)) u_dp (
    .clk, .cmd, .addr, .wgt,
    .err({in.data.err_blue, in.data.err_green, in.data.err_red}),
    .src({in.data.src_blue, in.data.src_green, in.data.src_red}),
    .adj);

  assign out.data.adj_red     = zero ? '0 : adj[0 +: AdjW];
  assign out.data.adj_green   = zero ? '0 : adj[AdjW +: AdjW];
  assign out.data.adj_blue    = zero ? '0 : adj[2*AdjW +: AdjW];
  assign out.data.coord_error = cerr;
endmodule

// ===== dv/tb_error_diffusion_buffer.sv =====
// Testbench for error_diffusion_buffer: directed and random read and distribute words,
// checked against a behavioral model of the per-pixel error store.
// Depends on edb_pkg, edb_if and the error_diffusion_buffer RTL.
`timescale 1ns / 100ps

module tb_error_diffusion_buffer;
  import edb_pkg::*;

  typedef struct packed {
    logic                    func;
    logic [7:0]              pos_x;
    logic [7:0]              pos_y;
    logic [SrcW-1:0]         src_red;
    logic [SrcW-1:0]         src_green;
    logic [SrcW-1:0]         src_blue;
    logic signed [ErrW-1:0]  err_red;
    logic signed [ErrW-1:0]  err_green;
    logic signed [ErrW-1:0]  err_blue;
  } pix_in_t;

  typedef struct packed {
    logic signed [AdjW-1:0] adj_red;
    logic signed [AdjW-1:0] adj_green;
    logic signed [AdjW-1:0] adj_blue;
    logic                   coord_error;
  } pix_out_t;

  localparam int StoreMax = 8388607;
  localparam int StoreMin = -8388608;

  class error_store_model;
    int red_err[MaxWidthDef*MaxHeightDef];
    int green_err[MaxWidthDef*MaxHeightDef];
    int blue_err[MaxWidthDef*MaxHeightDef];
    int unsigned img_w = 256;
    int unsigned img_h = 192;
    logic [23:0] weights = '0;
    bit avg_on = 0;
    pix_out_t pending_adj[$];
    int errors = 0;

    function int unsigned eff_w();
      return (img_w < MaxWidthDef) ? img_w : MaxWidthDef;
    endfunction

    function int unsigned eff_h();
      return (img_h < MaxHeightDef) ? img_h : MaxHeightDef;
    endfunction

    function int sat24(longint v);
      if (v > StoreMax) return StoreMax;
      if (v < StoreMin) return StoreMin;
      return int'(v);
    endfunction

    function logic signed [15:0] adjusted(logic [11:0] src, int stored, bit avg);
      longint e;
      longint sum;
      longint r;
      e = avg ? stored / 3 : stored;
      sum = longint'(src) * 16 + e;
      r = sum / 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void spread(int unsigned x, int unsigned y, int er, int eg, int eb,
                         int unsigned wt);
      int unsigned a;
      if (wt == 0 || x >= eff_w() || y >= eff_h()) return;
      a = y * MaxWidthDef + x;
      red_err[a] = sat24(longint'(red_err[a]) + longint'(er) * wt);
      green_err[a] = sat24(longint'(green_err[a]) + longint'(eg) * wt);
      blue_err[a] = sat24(longint'(blue_err[a]) + longint'(eb) * wt);
    endfunction

    function void note_word(pix_in_t w);
      pix_out_t r;
      int unsigned x;
      int unsigned y;
      int unsigned a;
      int er;
      int eg;
      int eb;
      bit avg;
      r = '0;
      x = w.pos_x;
      y = w.pos_y;
      if (x >= eff_w() || y >= eff_h()) begin
        r.coord_error = 1'b1;
      end else if (w.func == FuncRead) begin
        a = y * MaxWidthDef + x;
        avg = avg_on && (y != 0);
        r.adj_red = adjusted(w.src_red, red_err[a], avg);
        r.adj_green = adjusted(w.src_green, green_err[a], avg);
        r.adj_blue = adjusted(w.src_blue, blue_err[a], avg);
      end else begin
        er = w.err_red;
        eg = w.err_green;
        eb = w.err_blue;
        if (x > 0) spread(x - 1, y + 1, er, eg, eb, weights[3:0]);
        spread(x, y + 1, er, eg, eb, weights[7:4]);
        spread(x + 1, y + 1, er, eg, eb, weights[11:8]);
        spread(x + 1, y, er, eg, eb, weights[15:12]);
        spread(x + 2, y, er, eg, eb, weights[19:16]);
        spread(x, y + 2, er, eg, eb, weights[23:20]);
      end
      pending_adj.push_back(r);
    endfunction

    function void check_word(pix_out_t got);
      pix_out_t exp_w;
      if (pending_adj.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      exp_w = pending_adj.pop_front();
      if (got.adj_red !== exp_w.adj_red) begin
        $error("adj_red expected %0d actual %0d", exp_w.adj_red, got.adj_red);
        errors++;
      end
      if (got.adj_green !== exp_w.adj_green) begin
        $error("adj_green expected %0d actual %0d", exp_w.adj_green, got.adj_green);
        errors++;
      end
      if (got.adj_blue !== exp_w.adj_blue) begin
        $error("adj_blue expected %0d actual %0d", exp_w.adj_blue, got.adj_blue);
        errors++;
      end
      if (got.coord_error !== exp_w.coord_error) begin
        $error("coord_error expected %0d actual %0d", exp_w.coord_error, got.coord_error);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  edb_if #(.T(pix_in_t)) in_ch ();
  edb_if #(.T(pix_out_t)) out_ch ();

  error_diffusion_buffer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in         (in_ch),
    .out        (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  error_store_model store_model = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) store_model.check_word(out_ch.data);
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready = 1'b0;
    else out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = addr;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, logic [23:0] k, bit avg);
    wait (store_model.pending_adj.size() == 0);
    repeat (20) @(negedge clk);
    cfg_write(RegWidth, w);
    cfg_write(RegHeight, h);
    cfg_write(RegKernel, 32'(k));
    cfg_write(RegAvg, 32'(avg));
    store_model.img_w = w;
    store_model.img_h = h;
    store_model.weights = k;
    store_model.avg_on = avg;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(pix_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = w;
    do @(posedge clk); while (!in_ch.ready);
    store_model.note_word(w);
    @(negedge clk);
  endtask

  function automatic pix_in_t make_word(bit f, int unsigned x, int unsigned y,
                                        logic [11:0] src, logic [15:0] er,
                                        logic [15:0] eg, logic [15:0] eb);
    pix_in_t w;
    w.func = f;
    w.pos_x = 8'(x);
    w.pos_y = 8'(y);
    w.src_red = src;
    w.src_green = ~src;
    w.src_blue = src ^ 12'h5A5;
    w.err_red = er;
    w.err_green = eg;
    w.err_blue = eb;
    return w;
  endfunction

  task automatic send_random_word();
    pix_in_t w;
    int unsigned ew;
    int unsigned eh;
    int sel;
    ew = store_model.eff_w();
    eh = store_model.eff_h();
    w.func = 1'($urandom_range(0, 1));
    if (ew > 0 && eh > 0 && $urandom_range(0, 99) < 85) begin
      w.pos_x = 8'($urandom_range(0, ew - 1));
      w.pos_y = 8'($urandom_range(0, eh - 1));
    end else begin
      w.pos_x = 8'($urandom_range(0, 255));
      w.pos_y = 8'($urandom_range(0, 255));
    end
    w.src_red = 12'($urandom_range(0, 4095));
    w.src_green = 12'($urandom_range(0, 4095));
    w.src_blue = 12'($urandom_range(0, 4095));
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      w.err_red = 16'($urandom_range(0, 65535));
      w.err_green = 16'($urandom_range(0, 65535));
      w.err_blue = 16'($urandom_range(0, 65535));
    end else begin
      w.err_red = 16'($signed($urandom_range(0, 1023)) - 512);
      w.err_green = 16'($signed($urandom_range(0, 1023)) - 512);
      w.err_blue = 16'($signed($urandom_range(0, 1023)) - 512);
    end
    send_word(w);
  endtask

  int unsigned phase_w[12] = '{256, 1, 511, 16, 3, 0, 256, 8, 2, 255, 4, 5};
  int unsigned phase_h[12] = '{192, 256, 1, 9, 3, 7, 511, 8, 2, 0, 4, 5};

  initial begin
    logic [23:0] k;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset state: zero store, reset dimensions.
    send_word(make_word(FuncRead, 0, 0, 12'h000, 0, 0, 0));
    send_word(make_word(FuncRead, 255, 191, 12'hFFF, 0, 0, 0));
    send_word(make_word(FuncRead, 0, 192, 12'hFFF, 0, 0, 0));
    send_word(make_word(FuncDist, 255, 192, 12'h000, 16'h7FFF, 0, 0));
    in_ch.valid = 1'b0;
    configure(256, 192, 24'hFFFFFF, 0);
    send_word(make_word(FuncDist, 255, 191, 12'h000, 16'h7FFF, 16'h8000, 16'h0001));
    send_word(make_word(FuncDist, 254, 190, 12'h000, 16'h8000, 16'h7FFF, 16'hFFFF));
    repeat (18) send_word(make_word(FuncDist, 0, 0, 12'h000, 16'h8000, 16'h7FFF, 16'h8000));
    send_word(make_word(FuncRead, 1, 0, 12'hFFF, 0, 0, 0));
    send_word(make_word(FuncRead, 0, 2, 12'h000, 0, 0, 0));
    in_ch.valid = 1'b0;
    configure(256, 192, 24'hFFFFFF, 1);
    send_word(make_word(FuncRead, 1, 1, 12'h800, 0, 0, 0));
    send_word(make_word(FuncRead, 2, 0, 12'h000, 0, 0, 0));
    send_word(make_word(FuncRead, 255, 191, 12'hFFF, 0, 0, 0));
    in_ch.valid = 1'b0;

    for (int p = 0; p < 12; p++) begin
      if (p == 2) k = 24'h000000;
      else if (p == 6) k = 24'hFFFFFF;
      else k = 24'($urandom_range(0, 24'hFFFFFF));
      configure(phase_w[p], phase_h[p], k, p[0]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 51; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 51; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (170) send_random_word();
      in_ch.valid = 1'b0;
    end

    wait (store_model.pending_adj.size() == 0);
    repeat (30) @(posedge clk);
    if (store_model.errors == 0 && store_model.pending_adj.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== error_diffusion_buffer.f =====
rtl/edb_pkg.sv
rtl/edb_if.sv
rtl/edb_ram.sv
rtl/edb_datapath.sv
rtl/edb_ctrl.sv
rtl/error_diffusion_buffer.sv
dv/tb_error_diffusion_buffer.sv
